// File: rtl/pcm_sample_format_encoder_macros.svh
// ----------------------------------------------------------------------------
// PCM sample format encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PCM_SAMPLE_FORMAT_ENCODER_MACROS_SVH
`define PCM_SAMPLE_FORMAT_ENCODER_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define PCM_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a consequence holds in the cycle after an antecedent.
`define PCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pcm_pkg.sv
// ----------------------------------------------------------------------------
// PCM encoder package
// Register map, encoding and channel codes, and the configuration struct.
// ----------------------------------------------------------------------------
package pcm_pkg;

	// Register indexes on the APB port
	typedef enum logic [1:0] {
		REG_ENCODING     = 2'd0,
		REG_WIDE_OUTPUT  = 2'd1,
		REG_SOURCE_WIDE  = 2'd2,
		REG_CHANNEL_MODE = 2'd3
	} reg_idx_t;

	// Encoding codes
	localparam logic [1:0] ENC_SIGNED   = 2'd0;
	localparam logic [1:0] ENC_UNSIGNED = 2'd1;
	localparam logic [1:0] ENC_DELTA    = 2'd2;

	// Channel selection codes
	localparam logic [1:0] CH_LEFT    = 2'd0;
	localparam logic [1:0] CH_AVERAGE = 2'd1;
	localparam logic [1:0] CH_RIGHT   = 2'd2;

	// Midpoint offsets for the unsigned encoding
	localparam logic [15:0] OFFSET_WIDE   = 16'h8000;
	localparam logic [15:0] OFFSET_NARROW = 16'h0080;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [1:0] encoding;
		logic       wide_output;
		logic       source_wide;
		logic [1:0] channel_mode;
	} cfg_t;

endpackage

// File: rtl/pcm_sample_format_encoder.sv
// Throughput: one sample per cycle while the word output is not stalled; each
// sample passes from the input register to the result register in one pass.
// A stalled word holds the result register; the input register keeps accepting
// until it too is full.
// Reset: asynchronous, active low; clears config, predictor and valid flags.
// ----------------------------------------------------------------------------
// PCM sample format encoder
// Encodes sample frames as signed, unsigned or delta PCM words, 8 or 16 bits.
// ----------------------------------------------------------------------------
module pcm_sample_format_encoder
	import pcm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic               first_sample,
	input  logic signed [15:0] left_sample,
	input  logic signed [15:0] right_sample,
	input  logic               last_sample,
	output logic               word_valid,
	input  logic               word_ready,
	output logic [15:0]        out_word,
	output logic               end_of_run
);

	cfg_t cfg;

	// Configuration registers
	pcm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Encoding datapath
	pcm_enc u_enc (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.first_sample (first_sample),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_sample  (last_sample),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.out_word     (out_word),
		.end_of_run   (end_of_run)
	);

endmodule

// File: rtl/pcm_cfg.sv
// ----------------------------------------------------------------------------
// PCM encoder configuration registers
// APB write and read access to the four format control registers.
// ----------------------------------------------------------------------------
module pcm_cfg
	import pcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	// Write the selected register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_ENCODING:     cfg_q.encoding     <= pwdata[1:0];
				REG_WIDE_OUTPUT:  cfg_q.wide_output  <= pwdata[0];
				REG_SOURCE_WIDE:  cfg_q.source_wide  <= pwdata[0];
				REG_CHANNEL_MODE: cfg_q.channel_mode <= pwdata[1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_ENCODING:     prdata[1:0] = cfg_q.encoding;
			REG_WIDE_OUTPUT:  prdata[0]   = cfg_q.wide_output;
			REG_SOURCE_WIDE:  prdata[0]   = cfg_q.source_wide;
			REG_CHANNEL_MODE: prdata[1:0] = cfg_q.channel_mode;
			default:          prdata      = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/pcm_enc.sv
// ----------------------------------------------------------------------------
// PCM encoder datapath
// Input register, channel reduce and combine, encode, and result register.
// ----------------------------------------------------------------------------
`include "pcm_sample_format_encoder_macros.svh"

module pcm_enc
	import pcm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic               first_sample,
	input  logic signed [15:0] left_sample,
	input  logic signed [15:0] right_sample,
	input  logic               last_sample,
	output logic               word_valid,
	input  logic               word_ready,
	output logic [15:0]        out_word,
	output logic               end_of_run
);

	logic               valid_s1;
	logic               first_s1;
	logic               last_s1;
	logic signed [15:0] left_s1;
	logic signed [15:0] right_s1;
	logic               valid_s2;
	logic [15:0]        word_s2;
	logic               last_s2;
	logic [15:0]        previous_q;

	logic               adv_s2;
	logic               move_s1;
	logic signed [15:0] a_val;
	logic signed [15:0] b_val;
	logic signed [16:0] sum_val;
	logic signed [15:0] frame_val;
	logic [15:0]        pred_val;
	logic [15:0]        raw_word;
	logic [15:0]        word_val;

	// Reduce one channel to a signed value at the output width
	function automatic logic signed [15:0] reduce(input logic [15:0] raw, input cfg_t c);
		logic signed [15:0] r;
		if (!c.source_wide) begin
			r = {{8{raw[7]}}, raw[7:0]};
		end else if (c.wide_output) begin
			r = raw;
		end else begin
			r = {{8{raw[15]}}, raw[15:8]};
		end
		return r;
	endfunction

	// Handshake: result stage frees when empty or taken
	assign adv_s2       = !valid_s2 || word_ready;
	assign move_s1      = valid_s1 && adv_s2;
	assign sample_ready = !valid_s1 || adv_s2;

	// Capture an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			first_s1 <= first_sample;
			last_s1  <= last_sample;
			left_s1  <= left_sample;
			right_s1 <= right_sample;
		end
	end

	// Combine channels; the average rounds to nearest, ties toward plus infinity
	always_comb begin
		a_val   = reduce(left_s1, cfg);
		b_val   = reduce(right_s1, cfg);
		sum_val = {a_val[15], a_val} + {b_val[15], b_val} + 17'sd1;
		case (cfg.channel_mode)
			CH_AVERAGE: frame_val = sum_val[16:1];
			CH_RIGHT:   frame_val = b_val;
			default:    frame_val = a_val;
		endcase
	end

	// Encode and trim to the output width
	always_comb begin
		pred_val = first_s1 ? 16'h0000 : previous_q;
		case (cfg.encoding)
			ENC_DELTA:    raw_word = frame_val - pred_val;
			ENC_UNSIGNED: raw_word = frame_val + (cfg.wide_output ? OFFSET_WIDE : OFFSET_NARROW);
			default:      raw_word = frame_val;
		endcase
		word_val = cfg.wide_output ? raw_word : {8'h00, raw_word[7:0]};
	end

	// Update the delta predictor as each transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_q <= '0;
		end else if (move_s1) begin
			if (cfg.encoding == ENC_DELTA) begin
				previous_q <= frame_val;
			end else if (first_s1) begin
				previous_q <= '0;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			word_s2 <= word_val;
			last_s2 <= last_s1;
		end
	end

	assign word_valid = valid_s2;
	assign out_word   = word_s2;
	assign end_of_run = last_s2;

	`PCM_ASSERT(a_ready_when_empty, !valid_s1 |-> sample_ready, "input stage empty but not ready")
	`PCM_ASSERT_NEXT(a_hold_result, valid_s2 && !word_ready, valid_s2 && $stable(word_s2),
		"stalled result lost or changed")
	`PCM_ASSERT_NEXT(a_hold_input, valid_s1 && !adv_s2, valid_s1 && $stable(left_s1),
		"blocked input stage lost or changed")
	`PCM_ASSERT_NEXT(a_pred_stable, !move_s1, $stable(previous_q),
		"predictor changed with no transaction moving")

endmodule

// File: test/pcm_sample_format_encoder_tb.sv
// ----------------------------------------------------------------------------
// PCM sample format encoder testbench
// Drives sample frames through the valid/ready input, programs the format
// registers over APB between phases, and checks every encoded word against a
// cycle-free predictor of the encoder. Covers directed extremes and special
// codes, random runs over random formats with random stalls, then a full-rate run.
// ----------------------------------------------------------------------------
module pcm_sample_format_encoder_tb;
	import pcm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Codes with no name in the package; the encoder treats them as defaults
	localparam logic [1:0] ENC_UNUSED = 2'd3;
	localparam logic [1:0] CH_UNUSED  = 2'd3;

	typedef struct {
		logic [15:0] word;
		logic        end_flag;
	} pcm_word_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               sample_valid;
	logic               sample_ready;
	logic               first_sample;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic               last_sample;
	logic               word_valid;
	logic               word_ready;
	logic [15:0]        out_word;
	logic               end_of_run;

	// Predictor state: format registers and the delta history
	cfg_t        format_cfg;
	logic [15:0] delta_history;
	pcm_word_t   pending_words[$];

	int mismatch_count;
	int frame_count;
	int write_count;
	bit no_idle;

	pcm_sample_format_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.first_sample (first_sample),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.last_sample  (last_sample),
		.word_valid   (word_valid),
		.word_ready   (word_ready),
		.out_word     (out_word),
		.end_of_run   (end_of_run)
	);

	always #2 clk = ~clk;

	// Stall the word output now and then, except in the no-idle stretch
	always @(posedge clk) begin
		word_ready <= no_idle || ($urandom_range(99) >= 9);
	end

	// Reduce one channel to a signed value at the output width
	function automatic logic signed [15:0] reduce_channel(logic [15:0] raw);
		if (!format_cfg.source_wide)
			return {{8{raw[7]}}, raw[7:0]};
		else if (format_cfg.wide_output)
			return raw;
		else
			return {{8{raw[15]}}, raw[15:8]};
	endfunction

	// Compute the encoded word for one frame and advance the delta history
	function automatic pcm_word_t encode_frame(logic first, logic [15:0] left,
			logic [15:0] right, logic last);
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [16:0] sum;
		logic [15:0]        v;
		logic [15:0]        mask;
		logic [15:0]        offset;
		pcm_word_t          res;

		a = reduce_channel(left);
		b = reduce_channel(right);
		mask = format_cfg.wide_output ? 16'hFFFF : 16'h00FF;
		offset = format_cfg.wide_output ? OFFSET_WIDE : OFFSET_NARROW;
		if (first)
			delta_history = '0;

		// Floor of (a + b + 1) / 2 via an arithmetic drop of the low bit
		sum = 17'(a) + 17'(b) + 17'sd1;
		case (format_cfg.channel_mode)
			CH_AVERAGE: v = sum[16:1];
			CH_RIGHT:   v = b;
			default:    v = a;
		endcase

		case (format_cfg.encoding)
			ENC_DELTA: begin
				res.word = (v - delta_history) & mask;
				delta_history = v;
			end
			ENC_UNSIGNED: res.word = (v + offset) & mask;
			default:      res.word = v & mask;
		endcase
		res.end_flag = last;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("[%0t] mismatch on %s: got 0x%04h, expected 0x%04h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Compare each word taken from the encoder with the oldest prediction
	always @(posedge clk) begin
		pcm_word_t want;
		if (arst_n && word_valid && word_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", out_word, 16'h0);
			end else begin
				want = pending_words.pop_front();
				if (out_word !== want.word)
					report_mismatch("out_word", out_word, want.word);
				if (end_of_run !== want.end_flag)
					report_mismatch("end_of_run", {15'd0, end_of_run},
						{15'd0, want.end_flag});
			end
		end
	end

	// Send one frame; occasionally drop valid first, except in the no-idle stretch
	task automatic send_sample(logic first, logic [15:0] left, logic [15:0] right,
			logic last);
		if (!no_idle && $urandom_range(99) < 9) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		first_sample <= first;
		left_sample  <= left;
		right_sample <= right;
		last_sample  <= last;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		pending_words.push_back(encode_frame(first, left, right, last));
		frame_count++;
	endtask

	// Hold off the sender until every predicted word has come out
	task automatic wait_for_idle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_ENCODING:     format_cfg.encoding     = value[1:0];
			REG_WIDE_OUTPUT:  format_cfg.wide_output  = value[0];
			REG_SOURCE_WIDE:  format_cfg.source_wide  = value[0];
			REG_CHANNEL_MODE: format_cfg.channel_mode = value[1:0];
		endcase
		write_count++;
	endtask

	// Drain the encoder, then program all four format registers
	task automatic apply_format(logic [1:0] enc, logic wide, logic src, logic [1:0] ch);
		wait_for_idle();
		write_register(REG_ENCODING, {30'd0, enc});
		write_register(REG_WIDE_OUTPUT, {31'd0, wide});
		write_register(REG_SOURCE_WIDE, {31'd0, src});
		write_register(REG_CHANNEL_MODE, {30'd0, ch});
	endtask

	// Mix extremes, small signed bytes, high-byte values and fully random words
	function automatic logic [15:0] pick_sample();
		logic [7:0] b;
		b = 8'($urandom);
		case ($urandom_range(9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return {{8{b[7]}}, b};
			3:       return {b, 8'h00};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [1:0] pick_encoding();
		case ($urandom_range(9))
			0, 1, 2: return ENC_SIGNED;
			3, 4, 5: return ENC_UNSIGNED;
			9:       return ENC_UNUSED;
			default: return ENC_DELTA;
		endcase
	endfunction

	function automatic logic [1:0] pick_channel();
		case ($urandom_range(9))
			0, 1, 2: return CH_LEFT;
			3, 4, 5: return CH_RIGHT;
			9:       return CH_UNUSED;
			default: return CH_AVERAGE;
		endcase
	endfunction

	// Send runs framed by first/last flags, with some broken framing
	task automatic send_runs(int frames);
		int sent;
		int len;
		logic f;
		logic l;
		sent = 0;
		while (sent < frames) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				f = (i == 0);
				l = (i == len - 1);
				if ($urandom_range(99) < 10) begin
					f = 1'($urandom_range(1));
					l = 1'($urandom_range(1));
				end
				send_sample(f, pick_sample(), pick_sample(), l);
			end
			sent += len;
		end
	endtask

	// Extremes and special codes, starting from the reset format
	task automatic test_directed();
		// Reset format: signed, narrow, narrow source, left
		send_sample(1'b1, 16'h0080, 16'h7F00, 1'b0);
		send_sample(1'b0, 16'h557F, 16'h8000, 1'b1);

		apply_format(ENC_SIGNED, 1'b1, 1'b1, CH_LEFT);
		send_sample(1'b1, 16'h7FFF, 16'h0000, 1'b0);
		send_sample(1'b0, 16'h8000, 16'hFFFF, 1'b0);
		send_sample(1'b0, 16'hFFFF, 16'h7FFF, 1'b1);

		// Wide source to narrow output: averaging of the high bytes
		apply_format(ENC_UNSIGNED, 1'b0, 1'b1, CH_AVERAGE);
		send_sample(1'b1, 16'h8000, 16'h8000, 1'b0);
		send_sample(1'b0, 16'h7FFF, 16'h7FFF, 1'b0);
		send_sample(1'b0, 16'h7FFF, 16'h8000, 1'b0);
		send_sample(1'b0, 16'hFF00, 16'h0000, 1'b1);

		// Narrow source to wide output, delta with predictor clears
		apply_format(ENC_DELTA, 1'b1, 1'b0, CH_RIGHT);
		send_sample(1'b1, 16'h0000, 16'h127F, 1'b0);
		send_sample(1'b0, 16'h0000, 16'h3480, 1'b1);
		send_sample(1'b1, 16'h0000, 16'h0001, 1'b0);
		send_sample(1'b0, 16'h0000, 16'hFFFF, 1'b1);

		// Unused codes fall back to signed and left
		apply_format(ENC_UNUSED, 1'b0, 1'b0, CH_UNUSED);
		send_sample(1'b1, 16'hAB80, 16'h007F, 1'b0);
		send_sample(1'b0, 16'h00FF, 16'h0001, 1'b1);

		// Narrow delta wraps modulo 256
		apply_format(ENC_DELTA, 1'b0, 1'b1, CH_AVERAGE);
		send_sample(1'b1, 16'h7FFF, 16'h7FFF, 1'b0);
		send_sample(1'b0, 16'h8000, 16'h8000, 1'b0);
		send_sample(1'b0, 16'h7FFF, 16'h7FFF, 1'b1);

		apply_format(ENC_UNSIGNED, 1'b1, 1'b1, CH_AVERAGE);
		send_sample(1'b1, 16'h8000, 16'h8000, 1'b0);
		send_sample(1'b0, 16'h7FFF, 16'h8000, 1'b1);
	endtask

	// Random format per phase, framed runs within each phase
	task automatic test_random_formats(int phases);
		repeat (phases) begin
			apply_format(pick_encoding(), 1'($urandom_range(1)), 1'($urandom_range(1)),
				pick_channel());
			send_runs($urandom_range(25, 45));
		end
	endtask

	// Back-to-back frames with both sides always ready
	task automatic test_full_rate();
		apply_format(ENC_DELTA, 1'b1, 1'b1, CH_AVERAGE);
		no_idle = 1'b1;
		send_runs(120);
		wait_for_idle();
		no_idle = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		first_sample = 1'b0;
		left_sample = '0;
		right_sample = '0;
		last_sample = 1'b0;
		word_ready = 1'b0;
		format_cfg = '0;
		delta_history = '0;
		mismatch_count = 0;
		frame_count = 0;
		write_count = 0;
		no_idle = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_formats(36);
		test_full_rate();

		wait_for_idle();
		repeat (4) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch("words never delivered", 16'(pending_words.size()), 16'h0);

		$display("Encoded %0d frames across %0d register writes", frame_count, write_count);
		$display("Formats: all encodings, channel modes, widths, unused codes, delta clears");
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pcm_pkg.sv
rtl/pcm_cfg.sv
rtl/pcm_enc.sv
rtl/pcm_sample_format_encoder.sv
test/pcm_sample_format_encoder_tb.sv
